// ===== src/fss_pkg.sv =====
// ----------------------------------------------------------------------------
// fss_pkg
// Shared types, constants and helpers for the flash stimulus sequencer.
// ----------------------------------------------------------------------------
package fss_pkg;

  localparam logic [63:0] MIN_REST = 64'd42949672;  // 10 ms in 32.32
  localparam int          MAX_OUT  = 4;

  typedef enum logic [2:0] {
    PH_DONE      = 3'd0,
    PH_FLASH     = 3'd1,
    PH_DARK      = 3'd2,
    PH_REPREST   = 3'd3,
    PH_TRIALREST = 3'd4
  } phase_t;

  typedef enum logic [3:0] {
    MK_EXP_START   = 4'd0,
    MK_EXP_STOP    = 4'd1,
    MK_TRIAL_START = 4'd2,
    MK_TRIAL_STOP  = 4'd3,
    MK_SEG_START   = 4'd4,
    MK_SEG_STOP    = 4'd5,
    MK_REST_START  = 4'd6,
    MK_REST_STOP   = 4'd7,
    MK_FLASH_START = 4'd8,
    MK_FLASH_STOP  = 4'd9
  } marker_t;

  typedef enum logic [2:0] {
    REG_START_CODE = 3'd0,
    REG_FLASHES    = 3'd1,
    REG_REPS       = 3'd2,
    REG_TRIALS     = 3'd3,
    REG_FLASH_TIME = 3'd4,
    REG_DARK_TIME  = 3'd5,
    REG_REP_REST   = 3'd6,
    REG_TRIAL_REST = 3'd7
  } reg_index_t;

  // Duration tags: which register value goes with a marker
  typedef enum logic [2:0] {
    DUR_ZERO  = 3'd0,
    DUR_FLASH = 3'd1,
    DUR_DARK  = 3'd2,
    DUR_RREST = 3'd3,
    DUR_TREST = 3'd4
  } dur_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL0,
    ST_MUL1,
    ST_MUL2,
    ST_DIV_REP,
    ST_DIV_PER,
    ST_DECIDE,
    ST_EMIT
  } state_t;

  // Controller -> datapath commands
  typedef struct packed {
    logic take;        // latch input item
    logic mul_rep;     // rep_len = flashes * period
    logic mul_trial;   // trial_len = reps * rep_cycle
    logic div_rep_go;  // start in_trial % rep_cycle
    logic div_per_go;  // start in_rep % period
    logic decide;      // classify phase, build marker list
  } cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic is_event;
    logic armed;
    logic div_done;
    logic need_div;    // in trial window and not after trial end
    logic period_nz;
    logic [2:0] count; // markers built
  } stat_t;

  function automatic logic [63:0] at_least_min(input logic [63:0] v);
    at_least_min = (v < MIN_REST) ? MIN_REST : v;
  endfunction

endpackage

// ===== src/fss_divider.sv =====
// ----------------------------------------------------------------------------
// fss_divider
// Restoring remainder unit: one quotient bit per cycle.
// ----------------------------------------------------------------------------
module fss_divider (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [63:0] divisor,
  output logic        done,
  output logic [63:0] remainder
);
  logic [63:0] num;
  logic [63:0] rem;
  logic [63:0] dvs;
  logic [6:0]  count;
  logic        busy;
  logic [64:0] trial;

  assign trial     = {rem, num[63]};
  assign remainder = rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= 7'd0;
        num   <= dividend;
        dvs   <= divisor;
        rem   <= '0;
      end else if (busy) begin
        // shift in one bit, subtract when it fits
        if (trial >= {1'b0, dvs}) begin
          rem <= 64'(trial - {1'b0, dvs});
        end else begin
          rem <= trial[63:0];
        end
        num   <= {num[62:0], 1'b0};
        count <= count + 7'd1;
        if (count == 7'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

// ===== src/fss_datapath.sv =====
// ----------------------------------------------------------------------------
// fss_datapath
// Configuration, sequencer state, timing arithmetic and marker list.
// ----------------------------------------------------------------------------
module fss_datapath (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  input  logic [2:0]        cfg_index,
  input  logic [63:0]       cfg_data,
  input  logic              command,
  input  logic [63:0]       when,
  input  logic [63:0]       event_code,
  input  fss_pkg::cmd_t     cmd,
  input  logic [1:0]        emit_sel,
  output fss_pkg::stat_t    stat,
  output logic [3:0]        marker,
  output logic [63:0]       marker_time,
  output logic [63:0]       marker_duration
);
  import fss_pkg::*;

  logic [63:0] start_code;
  logic [11:0] flashes;
  logic [7:0]  reps;
  logic [15:0] trial_total;
  logic [47:0] flash_time, dark_time, rep_rest_time, trial_rest_time;

  logic        armed;
  phase_t      previous_phase;
  logic [63:0] trial_begin_time;
  logic [15:0] trial_number;

  logic        is_event;
  logic [63:0] now;
  logic [63:0] rep_len, rep_cycle, trial_len, in_trial, in_rep;
  logic        rep_div;
  marker_t     mk [MAX_OUT];
  dur_t        dr [MAX_OUT];
  logic [2:0]  count;

  logic [63:0] rrest, trest, period;
  assign rrest    = at_least_min({16'd0, rep_rest_time});
  assign trest    = at_least_min({16'd0, trial_rest_time});
  assign period   = 64'({16'd0, flash_time} + {16'd0, dark_time});
  assign in_trial = now - trial_begin_time;

  logic        div_start, div_done;
  logic [63:0] div_a, div_b, div_r;
  assign div_start = cmd.div_rep_go | cmd.div_per_go;
  assign div_a     = cmd.div_rep_go ? in_trial : in_rep;
  assign div_b     = cmd.div_rep_go ? rep_cycle : period;

  fss_divider u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_a),
    .divisor(div_b), .done(div_done), .remainder(div_r)
  );

  assign stat.is_event  = is_event;
  assign stat.armed     = armed;
  assign stat.div_done  = div_done;
  assign stat.need_div  = (now >= trial_begin_time) && (in_trial < trial_len);
  assign stat.period_nz = (period != 64'd0);
  assign stat.count     = count;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_code      <= '0;
      flashes         <= 12'd12;
      reps            <= 8'd12;
      trial_total     <= '0;
      flash_time      <= 48'd858993459;
      dark_time       <= 48'd429496729;
      rep_rest_time   <= 48'd4294967296;
      trial_rest_time <= 48'd8589934592;
    end else if (cfg_valid) begin
      case (reg_index_t'(cfg_index))
        REG_START_CODE: start_code      <= cfg_data;
        REG_FLASHES:    flashes         <= cfg_data[11:0];
        REG_REPS:       reps            <= cfg_data[7:0];
        REG_TRIALS:     trial_total     <= cfg_data[15:0];
        REG_FLASH_TIME: flash_time      <= cfg_data[47:0];
        REG_DARK_TIME:  dark_time       <= cfg_data[47:0];
        REG_REP_REST:   rep_rest_time   <= cfg_data[47:0];
        REG_TRIAL_REST: trial_rest_time <= cfg_data[47:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      is_event <= command;
      now      <= when;
    end
    if (cmd.mul_rep) begin
      rep_len <= 64'({52'd0, flashes} * period);
    end
    if (cmd.mul_trial) begin
      trial_len <= 64'({56'd0, reps} * rep_cycle);
    end
    // keep only the remainder of the repetition divide
    if (cmd.div_rep_go) begin
      rep_div <= 1'b1;
    end else if (cmd.div_per_go) begin
      rep_div <= 1'b0;
    end
    if (div_done && rep_div) begin
      in_rep <= div_r;
    end
  end
  assign rep_cycle = rep_len + rrest;

  // Phase decision and marker list
  phase_t     ph;
  logic       refire;
  logic [2:0] n;
  marker_t    mk_n [MAX_OUT];
  dur_t       dr_n [MAX_OUT];

  always_comb begin
    refire = 1'b0;
    if (now < trial_begin_time) begin
      ph = PH_TRIALREST;
    end else if (in_trial >= trial_len) begin
      if (trial_total == 16'd0 || trial_number < trial_total) begin
        ph = PH_TRIALREST;
        refire = 1'b1;
      end else begin
        ph = PH_DONE;
      end
    end else if (in_rep >= rep_len) begin
      ph = PH_REPREST;
    end else if (period != 64'd0 && div_r < {16'd0, flash_time}) begin
      ph = PH_FLASH;
    end else begin
      ph = PH_DARK;
    end
  end

  always_comb begin
    n = 3'd0;
    for (int i = 0; i < MAX_OUT; i++) begin
      mk_n[i] = MK_EXP_START;
      dr_n[i] = DUR_ZERO;
    end
    if (ph != previous_phase) begin
      case (previous_phase)
        PH_FLASH: begin
          mk_n[0] = MK_FLASH_STOP; dr_n[0] = DUR_DARK; n = 3'd1;
        end
        PH_REPREST: begin
          if (ph != PH_TRIALREST && ph != PH_DONE) begin
            mk_n[0] = MK_SEG_START; n = 3'd1;
          end
        end
        PH_TRIALREST: begin
          mk_n[0] = MK_REST_STOP; mk_n[1] = MK_TRIAL_START; n = 3'd2;
          if (ph != PH_DONE) begin
            mk_n[2] = MK_SEG_START; n = 3'd3;
          end
        end
        PH_DONE: begin
          mk_n[0] = MK_EXP_START; n = 3'd1;
        end
        default: ;
      endcase
      case (ph)
        PH_FLASH: begin
          mk_n[n[1:0]] = MK_FLASH_START; dr_n[n[1:0]] = DUR_FLASH; n = n + 3'd1;
        end
        PH_REPREST: begin
          mk_n[n[1:0]] = MK_SEG_STOP; dr_n[n[1:0]] = DUR_RREST; n = n + 3'd1;
        end
        PH_TRIALREST: begin
          if (previous_phase != PH_DONE) begin
            if (previous_phase != PH_REPREST) begin
              mk_n[n[1:0]] = MK_SEG_STOP; n = n + 3'd1;
            end
            mk_n[n[1:0]] = MK_TRIAL_STOP; n = n + 3'd1;
          end
          if (n < 3'd4) begin
            mk_n[n[1:0]] = MK_REST_START; dr_n[n[1:0]] = DUR_TREST; n = n + 3'd1;
          end
        end
        PH_DONE: begin
          if (previous_phase != PH_REPREST && previous_phase != PH_TRIALREST
              && n < 3'd4) begin
            mk_n[n[1:0]] = MK_SEG_STOP; n = n + 3'd1;
          end
          if (n < 3'd4) begin
            mk_n[n[1:0]] = MK_TRIAL_STOP; n = n + 3'd1;
          end
          if (n < 3'd4) begin
            mk_n[n[1:0]] = MK_EXP_STOP; n = n + 3'd1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      armed            <= 1'b0;
      previous_phase   <= PH_DONE;
      trial_begin_time <= '0;
      trial_number     <= 16'd1;
      count            <= '0;
    end else if (cmd.take && command) begin
      if (!armed && event_code == start_code) begin
        trial_begin_time <= when + trest;
        armed            <= 1'b1;
      end
    end else if (cmd.decide) begin
      count          <= n;
      mk             <= mk_n;
      dr             <= dr_n;
      previous_phase <= ph;
      if (refire) begin
        trial_begin_time <= now + trest;
        if (trial_number != 16'hFFFF) begin
          trial_number <= trial_number + 16'd1;
        end
      end
    end
  end

  // Output selection
  always_comb begin
    marker      = mk[emit_sel];
    marker_time = now;
    case (dr[emit_sel])
      DUR_FLASH: marker_duration = {16'd0, flash_time};
      DUR_DARK:  marker_duration = {16'd0, dark_time};
      DUR_RREST: marker_duration = rrest;
      DUR_TREST: marker_duration = trest;
      default:   marker_duration = '0;
    endcase
  end
endmodule

// ===== src/fss_controller.sv =====
// ----------------------------------------------------------------------------
// fss_controller
// Sequences multiply, divide, decide and emit steps for one item.
// ----------------------------------------------------------------------------
module fss_controller (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  output logic           final_res,
  output logic [1:0]     emit_sel,
  output fss_pkg::cmd_t  cmd,
  input  fss_pkg::stat_t stat
);
  import fss_pkg::*;

  state_t     state, state_next;
  logic [1:0] idx, idx_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      idx   <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
    end
  end

  always_comb begin
    state_next = state;
    idx_next   = idx;
    case (state)
      ST_IDLE:  if (in_valid) state_next = ST_MUL0;
      ST_MUL0:  begin
        if (stat.is_event || !stat.armed) state_next = ST_IDLE;
        else state_next = ST_MUL1;
      end
      ST_MUL1:  state_next = ST_MUL2;
      ST_MUL2:  state_next = stat.need_div ? ST_DIV_REP : ST_DECIDE;
      ST_DIV_REP: begin
        if (stat.div_done) state_next = stat.period_nz ? ST_DIV_PER : ST_DECIDE;
      end
      ST_DIV_PER: if (stat.div_done) state_next = ST_DECIDE;
      ST_DECIDE: begin
        idx_next   = '0;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (stat.count == 3'd0) begin
          state_next = ST_IDLE;
        end else if (out_ready) begin
          idx_next = idx + 2'd1;
          if ({1'b0, idx} == stat.count - 3'd1) state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Divides are started on entry to their state; a one-cycle pulse
  logic entered;
  always_ff @(posedge clk) begin
    if (rst) entered <= 1'b0;
    else entered <= (state_next != state);
  end

  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    final_res = 1'b0;
    emit_sel  = idx;
    case (state)
      ST_IDLE:    begin in_ready = 1'b1; cmd.take = in_valid; end
      ST_MUL0:    cmd.mul_rep = 1'b1;
      ST_MUL1:    cmd.mul_trial = 1'b1;
      ST_DIV_REP: cmd.div_rep_go = entered;
      ST_DIV_PER: cmd.div_per_go = entered;
      ST_DECIDE:  cmd.decide = 1'b1;
      ST_EMIT: begin
        out_valid = (stat.count != 3'd0);
        final_res = ({1'b0, idx} == stat.count - 3'd1);
      end
      default: ;
    endcase
  end
endmodule

// ===== src/flash_stimulus_sequencer_core.sv =====
// ----------------------------------------------------------------------------
// flash_stimulus_sequencer_core
// Timed flash stimulus sequencer, controller plus datapath.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one item: command, when,
//   event_code. Command 1 is an incoming event; a match on start_code arms
//   the block. Command 0 is a time tick that is placed in a phase.
//   Output channel (out_valid/out_ready) carries up to four markers per
//   tick; final_res flags the last one. A tick with no phase change or an
//   unarmed tick gives nothing.
//   Config channel (cfg_valid/cfg_ready) writes register cfg_index; write
//   only while idle. cfg_ready is always high.
//   Sequence: an event or an unarmed tick goes back to idle after MUL0. An
//   armed tick runs the multiplies, then up to two divides in the
//   bit-serial remainder unit (in_trial % rep_cycle, in_rep % period),
//   then decide, then one marker per cycle while out_ready is high.
//   One item is in flight at a time.
//   Reset: registers take their documented values, the block is unarmed.
//   Stall: markers hold on the output until taken; input stays not ready.
// ----------------------------------------------------------------------------
module flash_stimulus_sequencer_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        command,
  input  logic [63:0] when,
  input  logic [63:0] event_code,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  marker,
  output logic [63:0] marker_time,
  output logic [63:0] marker_duration,
  output logic        final_res
);
  import fss_pkg::*;

  cmd_t       cmd;
  stat_t      stat;
  logic [1:0] emit_sel;

  assign cfg_ready = 1'b1;

  fss_controller u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .final_res(final_res),
    .emit_sel(emit_sel), .cmd(cmd), .stat(stat)
  );

  fss_datapath u_dp (
    .clk(clk), .rst(rst), .cfg_valid(cfg_valid), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .command(command), .when(when),
    .event_code(event_code), .cmd(cmd), .emit_sel(emit_sel), .stat(stat),
    .marker(marker), .marker_time(marker_time),
    .marker_duration(marker_duration)
  );
endmodule

// ===== sim/fss_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fss_checker
// Watches the config, input and output channels of the flash stimulus
// sequencer, predicts the marker items of each tick and compares them.
// ----------------------------------------------------------------------------
module fss_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        command,
  input  logic [63:0] when,
  input  logic [63:0] event_code,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [3:0]  marker,
  input  logic [63:0] marker_time,
  input  logic [63:0] marker_duration,
  input  logic        final_res,
  output int          fail_count,
  output int          pending
);
  import fss_pkg::*;

  typedef struct {
    marker_t     mk;
    logic [63:0] t;
    logic [63:0] dur;
    logic        last;
  } marker_item_t;

  localparam logic [63:0] REST_FLOOR = 64'd42949672;

  marker_item_t expected_markers[$];
  marker_item_t tick_markers[$];

  logic [63:0] code_r;
  logic [11:0] flashes_r;
  logic [7:0]  reps_r;
  logic [15:0] trials_r;
  logic [47:0] flash_r, dark_r, rrest_r, trest_r;

  logic        armed;
  phase_t      prev_phase;
  logic [63:0] trial_begin;
  logic [15:0] trial_num;
  int          fails;

  task automatic add_marker(marker_t mk, logic [63:0] t, logic [63:0] d);
    marker_item_t m;
    m.mk = mk; m.t = t; m.dur = d; m.last = 1'b0;
    tick_markers.push_back(m);
  endtask

  task automatic sequence_tick(logic cmd, logic [63:0] now, logic [63:0] code);
    logic [63:0] rrest, trest, period, rep_len, rep_cycle, trial_len;
    logic [63:0] in_trial, in_rep;
    phase_t      ph, last;
    rrest = ({16'd0, rrest_r} < REST_FLOOR) ? REST_FLOOR : {16'd0, rrest_r};
    trest = ({16'd0, trest_r} < REST_FLOOR) ? REST_FLOOR : {16'd0, trest_r};
    period    = {16'd0, flash_r} + {16'd0, dark_r};
    rep_len   = {52'd0, flashes_r} * period;
    rep_cycle = rep_len + rrest;
    trial_len = {56'd0, reps_r} * rep_cycle;
    tick_markers.delete();
    if (cmd) begin
      if (!armed && code == code_r) begin
        trial_begin = now + trest;
        armed = 1'b1;
      end
      return;
    end
    if (!armed) return;
    if (now < trial_begin) begin
      ph = PH_TRIALREST;
    end else begin
      in_trial = now - trial_begin;
      in_rep   = in_trial % rep_cycle;
      if (in_trial >= trial_len) begin
        if (trials_r == 16'd0 || trial_num < trials_r) begin
          trial_begin = now + trest;
          ph = PH_TRIALREST;
          if (trial_num != 16'hFFFF) trial_num = trial_num + 16'd1;
        end else begin
          ph = PH_DONE;
        end
      end else if (in_rep >= rep_len) begin
        ph = PH_REPREST;
      end else if (period != 64'd0 && (in_rep % period) < {16'd0, flash_r}) begin
        ph = PH_FLASH;
      end else begin
        ph = PH_DARK;
      end
    end
    last = prev_phase;
    if (ph == last) return;
    case (last)
      PH_FLASH: add_marker(MK_FLASH_STOP, now, {16'd0, dark_r});
      PH_REPREST: begin
        if (ph != PH_TRIALREST && ph != PH_DONE) add_marker(MK_SEG_START, now, 64'd0);
      end
      PH_TRIALREST: begin
        add_marker(MK_REST_STOP, now, 64'd0);
        add_marker(MK_TRIAL_START, now, 64'd0);
        if (ph != PH_DONE) add_marker(MK_SEG_START, now, 64'd0);
      end
      PH_DONE: add_marker(MK_EXP_START, now, 64'd0);
      default: ;
    endcase
    case (ph)
      PH_FLASH:   add_marker(MK_FLASH_START, now, {16'd0, flash_r});
      PH_REPREST: add_marker(MK_SEG_STOP, now, rrest);
      PH_TRIALREST: begin
        if (last != PH_DONE) begin
          if (last != PH_REPREST) add_marker(MK_SEG_STOP, now, 64'd0);
          add_marker(MK_TRIAL_STOP, now, 64'd0);
        end
        add_marker(MK_REST_START, now, trest);
      end
      PH_DONE: begin
        if (last != PH_REPREST && last != PH_TRIALREST) add_marker(MK_SEG_STOP, now, 64'd0);
        add_marker(MK_TRIAL_STOP, now, 64'd0);
        add_marker(MK_EXP_STOP, now, 64'd0);
      end
      default: ;
    endcase
    prev_phase = ph;
    if (tick_markers.size() > 0) tick_markers[tick_markers.size()-1].last = 1'b1;
    foreach (tick_markers[i]) expected_markers.push_back(tick_markers[i]);
  endtask

  always @(posedge clk) begin
    marker_item_t e;
    if (rst) begin
      code_r = '0; flashes_r = 12'd12; reps_r = 8'd12; trials_r = '0;
      flash_r = 48'd858993459; dark_r = 48'd429496729;
      rrest_r = 48'd4294967296; trest_r = 48'd8589934592;
      armed = 1'b0; prev_phase = PH_DONE; trial_begin = '0; trial_num = 16'd1;
      fails = 0;
      expected_markers.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (reg_index_t'(cfg_index))
          REG_START_CODE: code_r    = cfg_data;
          REG_FLASHES:    flashes_r = cfg_data[11:0];
          REG_REPS:       reps_r    = cfg_data[7:0];
          REG_TRIALS:     trials_r  = cfg_data[15:0];
          REG_FLASH_TIME: flash_r   = cfg_data[47:0];
          REG_DARK_TIME:  dark_r    = cfg_data[47:0];
          REG_REP_REST:   rrest_r   = cfg_data[47:0];
          REG_TRIAL_REST: trest_r   = cfg_data[47:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (expected_markers.size() == 0) begin
          $display("%0t: unexpected marker item: actual marker=%0d time=%h dur=%h final=%b",
                   $time, marker, marker_time, marker_duration, final_res);
          fails++;
        end else begin
          e = expected_markers.pop_front();
          if (marker !== e.mk) begin
            $display("%0t: marker mismatch: expected %0d actual %0d", $time, e.mk, marker);
            fails++;
          end
          if (marker_time !== e.t) begin
            $display("%0t: marker_time mismatch: expected %h actual %h",
                     $time, e.t, marker_time);
            fails++;
          end
          if (marker_duration !== e.dur) begin
            $display("%0t: marker_duration mismatch: expected %h actual %h",
                     $time, e.dur, marker_duration);
            fails++;
          end
          if (final_res !== e.last) begin
            $display("%0t: final_res mismatch: expected %b actual %b",
                     $time, e.last, final_res);
            fails++;
          end
        end
      end
      if (in_valid && in_ready) sequence_tick(command, when, event_code);
    end
    fail_count <= fails;
    pending    <= expected_markers.size();
  end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the flash stimulus sequencer: directed arming and
// extreme-value ticks, then random tick streams under several register
// settings, with random and long output stalls. The checker predicts.
// ----------------------------------------------------------------------------
module tb_top;
  import fss_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_WAIT  = 200;   // a tick with no marker may still be in flight

  logic        clk, rst;
  logic        cfg_valid, cfg_ready;
  logic [2:0]  cfg_index;
  logic [63:0] cfg_data;
  logic        in_valid, in_ready, command;
  logic [63:0] when, event_code;
  logic        out_valid, out_ready;
  logic [3:0]  marker;
  logic [63:0] marker_time, marker_duration;
  logic        final_res;
  int          fail_count, pending;

  int          sent_items;
  logic [63:0] tick_now;
  logic [63:0] arm_code;
  int          cycles;

  flash_stimulus_sequencer_core u_dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .command(command), .when(when),
    .event_code(event_code),
    .out_valid(out_valid), .out_ready(out_ready), .marker(marker),
    .marker_time(marker_time), .marker_duration(marker_duration),
    .final_res(final_res)
  );

  fss_checker u_checker (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .command(command), .when(when),
    .event_code(event_code),
    .out_valid(out_valid), .out_ready(out_ready), .marker(marker),
    .marker_time(marker_time), .marker_duration(marker_duration),
    .final_res(final_res), .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Quiet window: neither side idles while these items go through.
  function automatic logic quiet_window();
    return sent_items >= 120 && sent_items < 170;
  endfunction

  // Receiver: random stalls, plus one long hold-off so the block backs up
  // and stops taking input while the sender keeps offering ticks.
  initial begin
    int  hold_cnt;
    logic held;
    hold_cnt = 0;
    held = 1'b0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!held && sent_items >= 200) begin
        held = 1'b1;
        hold_cnt = 800;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_ready <= 1'b0;
      end else if (quiet_window()) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= 10);
      end
    end
  end

  // Watchdog.
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // Leave valid high on return unless a random pause dropped it; the caller drops it before any pause.
  task automatic send_item(logic cmd, logic [63:0] t, logic [63:0] code);
    in_valid   <= 1'b1;
    command    <= cmd;
    when       <= t;
    event_code <= code;
    do @(posedge clk); while (!in_ready);
    sent_items++;
    if (!quiet_window() && $urandom_range(0, 99) < 10) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 30)) @(posedge clk);
    end
  endtask

  task automatic send_tick(logic [63:0] t);
    send_item(1'b0, t, {$urandom, $urandom});
  endtask

  // Drop valid, wait for every expected marker, then let a silent tick finish.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(reg_index_t idx, logic [63:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic load_settings(logic [63:0] fl, logic [63:0] reps, logic [63:0] trials,
                               logic [63:0] ft, logic [63:0] dt, logic [63:0] rr,
                               logic [63:0] tr);
    write_reg(REG_FLASHES, fl);
    write_reg(REG_REPS, reps);
    write_reg(REG_TRIALS, trials);
    write_reg(REG_FLASH_TIME, ft);
    write_reg(REG_DARK_TIME, dt);
    write_reg(REG_REP_REST, rr);
    write_reg(REG_TRIAL_REST, tr);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Random ticks: log-uniform time steps reach every phase scale, a few
  // jumps to arbitrary times exercise wrap, and ignored events as noise.
  task automatic random_ticks(int count);
    int r;
    logic [63:0] step;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 6) begin
        send_item(1'b1, {$urandom, $urandom}, ($urandom_range(0, 1) ? arm_code
                                                          : {$urandom, $urandom}));
        i--;
      end else if (r < 12) begin
        tick_now = {$urandom, $urandom};
        send_tick(tick_now);
      end else begin
        step = {$urandom, $urandom} >> $urandom_range(0, 63);
        tick_now = tick_now + step;
        send_tick(tick_now);
      end
      if (i == count / 2 && $urandom_range(0, 1)) drain();
    end
  endtask

  initial begin
    rst        <= 1'b1;
    cfg_valid  <= 1'b0;
    cfg_index  <= '0;
    cfg_data   <= '0;
    in_valid   <= 1'b0;
    command    <= 1'b0;
    when       <= '0;
    event_code <= '0;
    sent_items = 0;
    tick_now   = '0;
    arm_code   = {$urandom, 31'($urandom_range(1, 32'h7FFF_FFFE)), 1'b1};
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Short phases, minimum rests.
    write_reg(REG_START_CODE, arm_code);
    load_settings(64'd3, 64'd2, 64'd2, 64'd30000000, 64'd20000000, 64'd0, 64'd0);

    // Unarmed: ticks and non-matching events give nothing.
    send_tick(64'd0);
    send_tick(64'hFFFF_FFFF_FFFF_FFFF);
    send_item(1'b1, 64'd5, 64'd0);
    send_item(1'b1, 64'd6, 64'hFFFF_FFFF_FFFF_FFFF);
    send_tick(64'd100);
    // Arm at date 0; a second matching event is ignored.
    send_item(1'b1, 64'd0, arm_code);
    send_item(1'b1, 64'd500000000, arm_code);
    // Walk through rest, flash, dark, repetition rest, next trial, finish.
    send_tick(64'd1);
    send_tick(64'd42949672);
    send_tick(64'd60000000);
    send_tick(64'd80000000);
    send_tick(64'd100000000);
    send_tick(64'd130000000);
    send_tick(64'd200000000);
    send_tick(64'd250000000);
    send_tick(64'd400000000);
    send_tick(64'd700000000);
    send_tick(64'd800000000);
    send_tick(64'd2000000000);
    send_tick(64'd4000000000);
    send_tick(64'hFFFF_FFFF_FFFF_FFFF);
    drain();

    // Defaults-like timing, endless trials.
    load_settings(64'd12, 64'd12, 64'd0, 64'd858993459, 64'd429496729,
                  64'd4294967296, 64'd8589934592);
    tick_now = 64'd0;
    random_ticks(60);
    drain();

    // Largest values everywhere; lengths wrap.
    load_settings(64'hFFF, 64'hFF, 64'hFFFF, 64'hFFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF,
                  64'hFFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF);
    random_ticks(60);
    drain();

    // Smallest values: empty repetitions, single trial, direct finish.
    load_settings(64'd0, 64'd0, 64'd1, 64'd1, 64'd0, 64'd0, 64'd0);
    random_ticks(60);
    drain();

    // Random settings, at most four trials or endless trials.
    load_settings(64'($urandom_range(0, 20)), 64'($urandom_range(0, 6)),
                  64'($urandom_range(0, 4)),
                  {32'd0, $urandom_range(1, 32'hFFFF_FFFF)}, {32'd0, $urandom},
                  {32'd0, $urandom}, {32'd0, $urandom});
    random_ticks(60);
    drain();

    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/fss_pkg.sv
src/fss_divider.sv
src/fss_datapath.sv
src/fss_controller.sv
src/flash_stimulus_sequencer_core.sv
sim/fss_checker.sv
sim/tb_top.sv
